// ===== hdl/sdcd_pkg.sv =====
// Shared types and constants for the single/double click detector.
`timescale 1ns / 1ps

package sdcd_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned WIN_W    = 16;
    localparam int unsigned EVT_W    = 2;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 8;

    localparam logic [WIN_W-1:0] CLICK_WIN_RST = 16'd250;
    localparam logic [WIN_W-1:0] LOCK_WIN_RST  = 16'd500;

    typedef enum logic [EVT_W-1:0] {
        EVT_NEUTRAL = 2'd0,
        EVT_PUSH    = 2'd1,
        EVT_DOUBLE  = 2'd2
    } click_evt_t;

    typedef enum logic {
        REG_CLICK_WIN = 1'b0,
        REG_LOCK_WIN  = 1'b1
    } reg_sel_t;

endpackage

// ===== hdl/single_double_click_detector.sv =====
// Single/double click detector: poll register, event logic, result register, APB registers.
//
//   channel | direction | handshake            | payload
//   s_*     | in        | s_tvalid / s_tready  | now_ms, pressed
//   m_*     | out       | m_tvalid / m_tready  | click_event
//   apb     | in/out    | psel, penable, pready| double_click_window, double_lockout_window
//
// One poll per clock while m_tready does not stall; each poll is held in the poll register and
// then in the result register, which drives its result on m_*.
// The state update between the two registers (two 32-bit subtracts and
// compares) sets the cycle. rst_n clears all flags, stamps and windows to defaults.
// A stall on m_tready holds the result, then the poll register, then s_tready.
`timescale 1ns / 1ps

module single_double_click_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sdcd_pkg::S_DATA_W-1:0]   s_tdata,  // [31:0] now_ms, [32] pressed, [39:33] zero
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sdcd_pkg::M_DATA_W-1:0]   m_tdata,  // [1:0] click_event, [7:2] zero
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sdcd_pkg::APB_AW-1:0]     paddr,
    input  logic [sdcd_pkg::APB_DW-1:0]     pwdata,
    output logic [sdcd_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    logic [sdcd_pkg::WIN_W-1:0]  click_win_reg;
    logic [sdcd_pkg::WIN_W-1:0]  lock_win_reg;

    logic                        in_valid_reg;
    logic [sdcd_pkg::TIME_W-1:0] in_now_reg;
    logic                        in_down_reg;

    logic                        out_valid_reg;
    sdcd_pkg::click_evt_t        out_evt_reg;

    logic                        was_pressed_reg, was_pressed_next;
    logic                        pending_reg, pending_next;
    logic                        lockout_reg, lockout_next;
    logic [sdcd_pkg::TIME_W-1:0] release_stamp_reg, release_stamp_next;
    logic [sdcd_pkg::TIME_W-1:0] double_stamp_reg, double_stamp_next;
    sdcd_pkg::click_evt_t        evt_next;

    logic                        advance;
    logic                        cfg_wr;
    sdcd_pkg::reg_sel_t          cfg_sel;
    logic [sdcd_pkg::TIME_W-1:0] since_double;
    logic [sdcd_pkg::TIME_W-1:0] since_release;
    logic                        lockout_live;
    logic                        window_passed;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = sdcd_pkg::reg_sel_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_sel)
            sdcd_pkg::REG_CLICK_WIN: prdata = {{(sdcd_pkg::APB_DW-sdcd_pkg::WIN_W){1'b0}},
                                               click_win_reg};
            sdcd_pkg::REG_LOCK_WIN:  prdata = {{(sdcd_pkg::APB_DW-sdcd_pkg::WIN_W){1'b0}},
                                               lock_win_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_win_reg <= sdcd_pkg::CLICK_WIN_RST;
            lock_win_reg  <= sdcd_pkg::LOCK_WIN_RST;
        end
        else if (cfg_wr)
        begin
            if (cfg_sel == sdcd_pkg::REG_CLICK_WIN)
            begin
                click_win_reg <= pwdata[sdcd_pkg::WIN_W-1:0];
            end
            else
            begin
                lock_win_reg <= pwdata[sdcd_pkg::WIN_W-1:0];
            end
        end
    end

    // Move a poll on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_now_reg  <= s_tdata[sdcd_pkg::TIME_W-1:0];
            in_down_reg <= s_tdata[sdcd_pkg::TIME_W];
        end
    end

    assign since_double  = in_now_reg - double_stamp_reg;
    assign since_release = in_now_reg - release_stamp_reg;
    assign lockout_live  = lockout_reg &&
        !(since_double > {{(sdcd_pkg::TIME_W-sdcd_pkg::WIN_W){1'b0}}, lock_win_reg});
    assign window_passed =
        since_release > {{(sdcd_pkg::TIME_W-sdcd_pkg::WIN_W){1'b0}}, click_win_reg};

    always_comb
    begin
        was_pressed_next   = was_pressed_reg;
        pending_next       = pending_reg;
        lockout_next       = lockout_live;
        release_stamp_next = release_stamp_reg;
        double_stamp_next  = double_stamp_reg;
        evt_next           = sdcd_pkg::EVT_NEUTRAL;
        if (pending_reg && !lockout_live)
        begin
            if (window_passed && !in_down_reg)
            begin
                was_pressed_next = 1'b0;
                pending_next     = 1'b0;
                evt_next         = sdcd_pkg::EVT_PUSH;
            end
            else if (in_down_reg)
            begin
                was_pressed_next  = 1'b1;
                pending_next      = 1'b0;
                lockout_next      = 1'b1;
                double_stamp_next = in_now_reg;
                evt_next          = sdcd_pkg::EVT_DOUBLE;
            end
            else
            begin
                was_pressed_next = 1'b0;
            end
        end
        else if (in_down_reg)
        begin
            was_pressed_next = 1'b1;
        end
        else
        begin
            if (was_pressed_reg)
            begin
                pending_next       = 1'b1;
                release_stamp_next = in_now_reg;
            end
            else
            begin
                pending_next = 1'b0;
            end
            was_pressed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg   <= 1'b0;
            pending_reg       <= 1'b0;
            lockout_reg       <= 1'b0;
            release_stamp_reg <= '0;
            double_stamp_reg  <= '0;
            out_valid_reg     <= 1'b0;
            out_evt_reg       <= sdcd_pkg::EVT_NEUTRAL;
        end
        else
        begin
            if (advance)
            begin
                was_pressed_reg   <= was_pressed_next;
                pending_reg       <= pending_next;
                lockout_reg       <= lockout_next;
                release_stamp_reg <= release_stamp_next;
                double_stamp_reg  <= double_stamp_next;
                out_evt_reg       <= evt_next;
                out_valid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(sdcd_pkg::M_DATA_W-sdcd_pkg::EVT_W){1'b0}}, out_evt_reg};

endmodule

// ===== hdl/sdcd_checker.sv =====
// Port-level checker for the click detector and its bind.
`timescale 1ns / 1ps

module sdcd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sdcd_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          pready
);

    logic out_beat;
    logic out_double;

    assign out_beat   = m_tvalid && m_tready;
    assign out_double = out_beat &&
        (m_tdata[sdcd_pkg::EVT_W-1:0] == sdcd_pkg::EVT_DOUBLE);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == sdcd_pkg::M_DATA_W'(sdcd_pkg::EVT_NEUTRAL)) ||
                     (m_tdata == sdcd_pkg::M_DATA_W'(sdcd_pkg::EVT_PUSH)) ||
                     (m_tdata == sdcd_pkg::M_DATA_W'(sdcd_pkg::EVT_DOUBLE)))
        else $error("illegal click event code");

    a_no_back_double: assert property (@(posedge clk) disable iff (!rst_n)
        out_double |=> !out_double)
        else $error("double click reported on two adjacent polls");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind single_double_click_detector sdcd_checker u_sdcd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

// ===== sim/tb.sv =====
// Testbench for the single/double click detector: poll stream, event check, APB windows.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [sdcd_pkg::TIME_W-1:0] now_ms;
        logic                        pressed;
        logic                        typed;
        sdcd_pkg::click_evt_t        evt;
    } poll_row_t;

    localparam int unsigned DIR_ROWS   = 25;
    localparam int unsigned RAND_POLLS = 225;

    localparam poll_row_t POLL_TABLE [DIR_ROWS] = '{
        '{32'h0000_0000, 1'b0, 1'b1, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_000A, 1'b1, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_0014, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_0064, 1'b1, 1'b1, sdcd_pkg::EVT_DOUBLE},
        '{32'h0000_00C8, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_012C, 1'b1, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_0259, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_03E8, 1'b1, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_03F2, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_04EC, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_04ED, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_07D0, 1'b1, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_07DA, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_08D4, 1'b1, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_0AC8, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_0AC9, 1'b1, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'hFFFF_FFF0, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'hFFFF_FFF5, 1'b1, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_01F9, 1'b1, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_0300, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_0400, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h0000_0401, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h8000_0000, 1'b1, 1'b0, sdcd_pkg::EVT_NEUTRAL},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, sdcd_pkg::EVT_NEUTRAL}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sdcd_pkg::S_DATA_W-1:0] s_tdata;   // [31:0] now_ms, [32] pressed, [39:33] zero
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sdcd_pkg::M_DATA_W-1:0] m_tdata;   // [1:0] click_event, [7:2] zero
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sdcd_pkg::APB_AW-1:0]   paddr;
    logic [sdcd_pkg::APB_DW-1:0]   pwdata;
    logic [sdcd_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    logic [sdcd_pkg::WIN_W-1:0]    click_win;
    logic [sdcd_pkg::WIN_W-1:0]    lock_win;
    logic                          held;
    logic                          armed;
    logic                          lockout;
    logic [sdcd_pkg::TIME_W-1:0]   rel_stamp;
    logic [sdcd_pkg::TIME_W-1:0]   dbl_stamp;

    sdcd_pkg::click_evt_t          pending_events [$];
    int unsigned                   mismatches;
    bit                            no_idle;
    logic [sdcd_pkg::TIME_W-1:0]   poll_clock;
    logic                          level;

    single_double_click_detector DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic sdcd_pkg::click_evt_t detect_click(
        input logic [sdcd_pkg::TIME_W-1:0] now,
        input logic down);
        sdcd_pkg::click_evt_t        evt;
        logic [sdcd_pkg::TIME_W-1:0] since_rel;
        logic [sdcd_pkg::TIME_W-1:0] since_dbl;
        evt       = sdcd_pkg::EVT_NEUTRAL;
        since_dbl = now - dbl_stamp;
        since_rel = now - rel_stamp;
        if (lockout && since_dbl > {16'd0, lock_win})
            lockout = 1'b0;
        if (armed && !lockout)
        begin
            if (since_rel > {16'd0, click_win} && !down)
            begin
                held  = 1'b0;
                evt   = sdcd_pkg::EVT_PUSH;
                armed = 1'b0;
            end
            else if (down)
            begin
                held      = 1'b1;
                evt       = sdcd_pkg::EVT_DOUBLE;
                armed     = 1'b0;
                lockout   = 1'b1;
                dbl_stamp = now;
            end
            else
                held = 1'b0;
        end
        else if (down)
            held = 1'b1;
        else
        begin
            if (held)
            begin
                armed     = 1'b1;
                rel_stamp = now;
            end
            else
                armed = 1'b0;
            held = 1'b0;
        end
        return evt;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_poll(input logic [sdcd_pkg::TIME_W-1:0] now, input logic down,
                             input logic typed, input sdcd_pkg::click_evt_t typed_evt);
        int unsigned          gap;
        sdcd_pkg::click_evt_t evt;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, down, now};
        do
            @(posedge clk);
        while (!s_tready);
        evt = detect_click(now, down);
        pending_events.push_back(typed ? typed_evt : evt);
    endtask

    task automatic write_reg(input sdcd_pkg::reg_sel_t sel,
                             input logic [sdcd_pkg::WIN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == sdcd_pkg::REG_CLICK_WIN)
            click_win = value;
        else
            lock_win = value;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_polls(input int unsigned count);
        int unsigned                 sel;
        logic [sdcd_pkg::TIME_W-1:0] step;
        for (int unsigned n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 15);
            case (sel)
                0: step = $urandom - poll_clock;
                1: step = {16'd0, click_win} + $urandom_range(0, 1);
                2: step = {16'd0, lock_win} + $urandom_range(0, 1);
                3, 4, 5: step = $urandom_range(0, {16'd0, lock_win} + 2);
                default: step = $urandom_range(0, {16'd0, click_win} / 2 + 2);
            endcase
            poll_clock = poll_clock + step;
            if ($urandom_range(0, 1) == 0)
                level = ~level;
            send_poll(poll_clock, level, 1'b0, sdcd_pkg::EVT_NEUTRAL);
        end
    endtask

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin : rx_loop
            int unsigned          stall;
            sdcd_pkg::click_evt_t want;
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual click_event %0d",
                             $time, m_tdata[sdcd_pkg::EVT_W-1:0]);
                    mismatches++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (m_tdata[sdcd_pkg::EVT_W-1:0] !== want)
                    begin
                        $display("%0t: click_event expected %0d actual %0d",
                                 $time, want, m_tdata[sdcd_pkg::EVT_W-1:0]);
                        mismatches++;
                    end
                end
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = pick_gap();
                m_tready <= (stall == 0);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : main
        int unsigned                spin;
        logic [sdcd_pkg::WIN_W-1:0] wc;
        logic [sdcd_pkg::WIN_W-1:0] wl;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        mismatches = 0;
        no_idle    = 1'b0;
        click_win  = sdcd_pkg::CLICK_WIN_RST;
        lock_win   = sdcd_pkg::LOCK_WIN_RST;
        held       = 1'b0;
        armed      = 1'b0;
        lockout    = 1'b0;
        rel_stamp  = '0;
        dbl_stamp  = '0;
        poll_clock = $urandom;
        level      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int unsigned i = 0; i < DIR_ROWS; i++)
            send_poll(POLL_TABLE[i].now_ms, POLL_TABLE[i].pressed,
                      POLL_TABLE[i].typed, POLL_TABLE[i].evt);
        random_polls(RAND_POLLS);

        for (int unsigned ph = 0; ph < 5; ph++)
        begin
            drain();
            case (ph)
                0: begin wc = 16'd0;     wl = 16'd0;     end
                1: begin wc = 16'hFFFF;  wl = 16'hFFFF;  end
                2: begin wc = 16'd0;     wl = 16'hFFFF;  end
                3: begin wc = 16'hFFFF;  wl = 16'd0;     end
                default:
                begin
                    wc = 16'($urandom_range(1, 600));
                    wl = 16'($urandom_range(1, 900));
                end
            endcase
            write_reg(sdcd_pkg::REG_CLICK_WIN, wc);
            write_reg(sdcd_pkg::REG_LOCK_WIN, wl);
            no_idle = ($urandom_range(0, 3) == 0);
            random_polls(RAND_POLLS);
        end
        s_tvalid <= 1'b0;

        spin = 0;
        while (pending_events.size() != 0 && spin < 100_000)
        begin
            @(posedge clk);
            spin++;
        end
        if (pending_events.size() != 0)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            repeat (10) @(posedge clk);
            if (mismatches == 0 && pending_events.size() == 0)
                $display("tb: success");
            else
                $display("tb: failure");
            $finish;
        end
    end

endmodule
